// ===== src/gbps_pkg.sv =====
// Shared types, constants and helpers for the grid bin point store.
package gbps_pkg;

   localparam int GRID_DIV      = 16;
   localparam int CELL_CAPACITY = 16;

   localparam int COORD_W    = 20;
   localparam int LEN_W      = 19;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int GRID_BITS  = $clog2(GRID_DIV);
   localparam int NCELLS     = GRID_DIV * GRID_DIV;
   localparam int CELL_W     = $clog2(NCELLS);
   localparam int SLOT_W     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CELL_CAPACITY + 1);
   localparam int PT_AW      = CELL_W + SLOT_W;
   localparam int DIV_W      = (DIFF_W > LEN_W + GRID_BITS) ? DIFF_W : LEN_W + GRID_BITS;
   localparam int DIV_CNT_W  = $clog2(GRID_BITS + 1);
   localparam int CSR_AW     = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic [CELL_W-1:0]         cell_type;
   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [PT_AW-1:0]          pt_addr_type;
   typedef logic [GRID_BITS-1:0]      qidx_type;
   typedef logic [DIV_W-1:0]          div_type;
   typedef logic [DIV_CNT_W-1:0]      div_cnt_type;

   localparam coord_type FLOOR_Z = coord_type'(-524288);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_OUTSIDE  = 3'd1,
      STAT_OFF_GRID = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NO_SLOT  = 3'd4
   } status_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_WIN_MIN_X  = 3'd0,
      REG_WIN_MAX_X  = 3'd1,
      REG_WIN_MIN_Y  = 3'd2,
      REG_WIN_MAX_Y  = 3'd3,
      REG_ORIGIN_X   = 3'd4,
      REG_ORIGIN_Y   = 3'd5,
      REG_CELL_LEN_X = 3'd6,
      REG_CELL_LEN_Y = 3'd7
   } csr_index_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;

   typedef struct packed {
      cnt_type   cnt;
      coord_type top;
   } meta_type;

   typedef struct packed {
      logic [4:0] pad;
      logic [4:0] slot;
      logic [3:0] cell_y;
      logic [3:0] cell_x;
      coord_type  point_z;
      coord_type  point_y;
      coord_type  point_x;
      opcode_type opcode;
   } req_type;

   typedef struct packed {
      coord_type  out_z;
      coord_type  out_y;
      coord_type  out_x;
      coord_type  top_z;
      logic [4:0] cell_count;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic     done;
      logic     on_grid;
      qidx_type q;
   } div_res_type;

   function automatic cell_type cell_index(input int unsigned col, input int unsigned row);
      return cell_type'(col * GRID_DIV + row);
   endfunction

endpackage

// ===== src/gbps_div.sv =====
// Iterative restoring divider that finds a grid column or row from a signed offset.
module gbps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gbps_pkg::diff_type    dividend,
   input  gbps_pkg::len_type     divisor,
   output gbps_pkg::div_res_type res
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   gbps_pkg::div_cnt_type      cnt_ff, cnt_in;
   gbps_pkg::div_type          r_ff, r_in;
   gbps_pkg::div_type          d_ff, d_in;
   gbps_pkg::qidx_type         q_ff, q_in;
   logic                       neg_ff, neg_in;
   logic                       rng_ff, rng_in;

   logic [gbps_pkg::DIFF_W-1:0] mag;
   gbps_pkg::div_type           d_half;
   logic                        ge;
   logic [gbps_pkg::GRID_BITS:0] q_wide;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      rng_in  = rng_ff;
      mag     = dividend[gbps_pkg::DIFF_W-1] ? gbps_pkg::DIFF_W'(-dividend)
                                             : gbps_pkg::DIFF_W'(dividend);
      d_half  = d_ff >> 1;
      ge      = (r_ff >= d_half);
      q_wide  = {q_ff, ge};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[gbps_pkg::DIFF_W-1];
         r_in    = gbps_pkg::div_type'(mag);
         d_in    = gbps_pkg::div_type'(divisor) << gbps_pkg::GRID_BITS;
         q_in    = '0;
         rng_in  = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            rng_in = (r_ff < d_ff);
         end else begin
            d_in = d_half;
            r_in = ge ? r_ff - d_half : r_ff;
            q_in = q_wide[gbps_pkg::GRID_BITS-1:0];
         end
         if (cnt_ff == gbps_pkg::div_cnt_type'(gbps_pkg::GRID_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      rng_ff <= rng_in;
   end

   // A negative offset lands on the grid only when its quotient truncates to zero.
   assign res.done    = done_ff;
   assign res.on_grid = rng_ff && (!neg_ff || (q_ff == '0));
   assign res.q       = q_ff;

endmodule

// ===== src/gbps_point_ram.sv =====
// Point memory holding the stored points of every cell, one registered read port.
module gbps_point_ram (
   input  logic                  clock,
   input  logic                  we,
   input  gbps_pkg::pt_addr_type waddr,
   input  gbps_pkg::point_type   wdata,
   input  gbps_pkg::pt_addr_type raddr,
   output gbps_pkg::point_type   rdata
);

   gbps_pkg::point_type mem [(1 << gbps_pkg::PT_AW)];
   gbps_pkg::point_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/grid_bin_point_store_top.sv =====
// Top level of the grid bin point store: control, cell metadata memory and configuration.
//
// Requests arrive on req_ (tvalid/tready/tdata) and each opcode other than the
// unused one yields exactly one response on rsp_. Configuration registers are
// written through csr_we/csr_addr/csr_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce. One request
// is processed at a time; req_tready is high only while idle. An insert goes
// through these steps in order: the accepting edge captures the offsets, the
// check state tests the window and starts both dividers, the dividers do their
// range compare and then produce the four quotient bits, the cell metadata is
// read, the metadata and point memories get their read-modify-write, and the
// result loads the response register; only then is the next request accepted.
// A read presents its cell and slot to both memories at acceptance and loads
// the response register from their registered outputs. A clear drops the valid
// bit of every cell at acceptance and then responds. Reset restores the
// register defaults and empties all cells at once. A finished response waits
// in the output register while the receiver stalls; the next request is
// accepted meanwhile and holds only when its own response is ready before the
// previous one has been taken.
module grid_bin_point_store_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, point_x, point_y, point_z, cell_x, cell_y, slot, zero padding
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, cell_count, top_z, out_x, out_y, out_z
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [19:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_DIV   = 5'b00100,
      S_META  = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   gbps_pkg::coord_type win_min_x_ff, win_max_x_ff, win_min_y_ff, win_max_y_ff;
   gbps_pkg::coord_type origin_x_ff, origin_y_ff;
   gbps_pkg::len_type   len_x_ff, len_y_ff;

   gbps_pkg::opcode_type op_ff, op_in;
   gbps_pkg::coord_type  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   gbps_pkg::diff_type   dx_ff, dx_in, dy_ff, dy_in;
   logic [4:0]           slot_ff, slot_in;
   gbps_pkg::cell_type   cell_ff, cell_in;
   gbps_pkg::rsp_type    res_ff, res_in;
   gbps_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [gbps_pkg::NCELLS-1:0] valid_ff, valid_in;

   gbps_pkg::meta_type meta_mem [gbps_pkg::NCELLS];
   gbps_pkg::meta_type meta_rd_ff;
   gbps_pkg::meta_type meta_wdata;
   gbps_pkg::cell_type meta_raddr;
   logic               meta_we;

   logic                  pt_we;
   gbps_pkg::pt_addr_type pt_waddr, pt_raddr;
   gbps_pkg::point_type   pt_wdata, pt_rdata;

   gbps_pkg::req_type     req;
   gbps_pkg::div_res_type div_x, div_y;
   logic                  div_start;
   gbps_pkg::cell_type    req_cell, div_cell;
   gbps_pkg::cnt_type     n;
   gbps_pkg::coord_type   top;
   gbps_pkg::coord_type   top_new;
   logic                  win_out;

   assign req = gbps_pkg::req_type'(req_tdata);

   gbps_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dx_ff),
      .divisor  (len_x_ff),
      .res      (div_x)
   );

   gbps_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dy_ff),
      .divisor  (len_y_ff),
      .res      (div_y)
   );

   gbps_point_ram u_point_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (pt_waddr),
      .wdata (pt_wdata),
      .raddr (pt_raddr),
      .rdata (pt_rdata)
   );

   always_comb begin
      req_cell = gbps_pkg::cell_index(int'(req.cell_x), int'(req.cell_y));
      div_cell = gbps_pkg::cell_index(int'(div_x.q), int'(div_y.q));
      win_out  = (px_ff < win_min_x_ff) || (px_ff > win_max_x_ff) ||
                 (py_ff < win_min_y_ff) || (py_ff > win_max_y_ff);
      n        = valid_ff[cell_ff] ? meta_rd_ff.cnt : '0;
      top      = valid_ff[cell_ff] ? meta_rd_ff.top : gbps_pkg::FLOOR_Z;
      top_new  = (pz_ff > top) ? pz_ff : top;

      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      slot_in      = slot_ff;
      cell_in      = cell_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      div_start  = 1'b0;
      meta_raddr = (state_ff == S_IDLE) ? req_cell : div_cell;
      meta_we    = 1'b0;
      meta_wdata = '{cnt: gbps_pkg::cnt_type'(n + 1'b1), top: top_new};
      pt_we      = 1'b0;
      pt_waddr   = {cell_ff, gbps_pkg::slot_type'(n)};
      pt_wdata   = '{z: pz_ff, y: py_ff, x: px_ff};
      pt_raddr   = {req_cell, gbps_pkg::slot_type'(req.slot)};
      req_tready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            res_in = '{out_z: '0, out_y: '0, out_x: '0, top_z: gbps_pkg::FLOOR_Z,
                       cell_count: '0, status: gbps_pkg::STAT_OK};
            if (req_tvalid) begin
               op_in   = req.opcode;
               px_in   = req.point_x;
               py_in   = req.point_y;
               pz_in   = req.point_z;
               dx_in   = gbps_pkg::diff_type'(req.point_x) - gbps_pkg::diff_type'(origin_x_ff);
               dy_in   = gbps_pkg::diff_type'(req.point_y) - gbps_pkg::diff_type'(origin_y_ff);
               slot_in = req.slot;
               cell_in = req_cell;
               case (req.opcode)
                  gbps_pkg::OP_INSERT: begin
                     state_in = S_CHECK;
                  end
                  gbps_pkg::OP_READ: begin
                     if ((int'(req.cell_x) >= gbps_pkg::GRID_DIV) ||
                         (int'(req.cell_y) >= gbps_pkg::GRID_DIV)) begin
                        res_in.status = gbps_pkg::STAT_OFF_GRID;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_META;
                     end
                  end
                  gbps_pkg::OP_CLEAR: begin
                     valid_in = '0;
                     state_in = S_FIN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (win_out) begin
               res_in.status = gbps_pkg::STAT_OUTSIDE;
               state_in      = S_FIN;
            end else if ((len_x_ff == '0) || (len_y_ff == '0)) begin
               res_in.status = gbps_pkg::STAT_OFF_GRID;
               state_in      = S_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_x.done) begin
               if (!div_x.on_grid || !div_y.on_grid ||
                   (int'(div_x.q) >= gbps_pkg::GRID_DIV) ||
                   (int'(div_y.q) >= gbps_pkg::GRID_DIV)) begin
                  res_in.status = gbps_pkg::STAT_OFF_GRID;
                  state_in      = S_FIN;
               end else begin
                  cell_in  = div_cell;
                  state_in = S_META;
               end
            end
         end
         S_META: begin
            res_in.cell_count = 5'(n);
            res_in.top_z      = top;
            if (op_ff == gbps_pkg::OP_READ) begin
               if ((int'(slot_ff) >= int'(n)) ||
                   (int'(slot_ff) >= gbps_pkg::CELL_CAPACITY)) begin
                  res_in.status = gbps_pkg::STAT_NO_SLOT;
               end else begin
                  res_in.status = gbps_pkg::STAT_OK;
                  res_in.out_x  = pt_rdata.x;
                  res_in.out_y  = pt_rdata.y;
                  res_in.out_z  = pt_rdata.z;
               end
            end else if (int'(n) >= gbps_pkg::CELL_CAPACITY) begin
               res_in.status = gbps_pkg::STAT_FULL;
            end else begin
               pt_we             = 1'b1;
               meta_we           = 1'b1;
               valid_in[cell_ff] = 1'b1;
               res_in.status     = gbps_pkg::STAT_OK;
               res_in.cell_count = 5'(meta_wdata.cnt);
               res_in.top_z      = top_new;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[cell_ff] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      slot_ff     <= slot_in;
      cell_ff     <= cell_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_min_x_ff <= gbps_pkg::coord_type'(-524288);
         win_max_x_ff <= gbps_pkg::coord_type'(524287);
         win_min_y_ff <= gbps_pkg::coord_type'(-524288);
         win_max_y_ff <= gbps_pkg::coord_type'(524287);
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         len_x_ff     <= gbps_pkg::len_type'(1024);
         len_y_ff     <= gbps_pkg::len_type'(1024);
      end else if (csr_we) begin
         case (gbps_pkg::csr_index_type'(csr_addr))
            gbps_pkg::REG_WIN_MIN_X:  win_min_x_ff <= csr_wdata;
            gbps_pkg::REG_WIN_MAX_X:  win_max_x_ff <= csr_wdata;
            gbps_pkg::REG_WIN_MIN_Y:  win_min_y_ff <= csr_wdata;
            gbps_pkg::REG_WIN_MAX_Y:  win_max_y_ff <= csr_wdata;
            gbps_pkg::REG_ORIGIN_X:   origin_x_ff  <= csr_wdata;
            gbps_pkg::REG_ORIGIN_Y:   origin_y_ff  <= csr_wdata;
            gbps_pkg::REG_CELL_LEN_X: len_x_ff     <= csr_wdata[gbps_pkg::LEN_W-1:0];
            gbps_pkg::REG_CELL_LEN_Y: len_y_ff     <= csr_wdata[gbps_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sim/tb_grid_bin_point_store_top.sv =====
// Self-checking testbench for the grid bin point store, with directed and random requests.
`timescale 1ns / 1ps

module tb_grid_bin_point_store_top;

   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 64;

   localparam gbps_pkg::coord_type COORD_MAX = gbps_pkg::coord_type'(524287);
   localparam gbps_pkg::coord_type COORD_MIN = gbps_pkg::coord_type'(-524288);
   localparam gbps_pkg::len_type   LEN_MAX   = gbps_pkg::len_type'(524287);

   class bin_store_mirror;
      gbps_pkg::coord_type win_min_x, win_max_x, win_min_y, win_max_y;
      gbps_pkg::coord_type org_x, org_y;
      gbps_pkg::len_type   len_x, len_y;
      logic [4:0]          counts [gbps_pkg::NCELLS];
      gbps_pkg::coord_type tops [gbps_pkg::NCELLS];
      gbps_pkg::point_type points [gbps_pkg::NCELLS][gbps_pkg::CELL_CAPACITY];
      gbps_pkg::rsp_type   cell_reports [$];
      int                  errors;

      function new();
         win_min_x = COORD_MIN;
         win_max_x = COORD_MAX;
         win_min_y = COORD_MIN;
         win_max_y = COORD_MAX;
         org_x = '0;
         org_y = '0;
         len_x = gbps_pkg::len_type'(1024);
         len_y = gbps_pkg::len_type'(1024);
         errors = 0;
         empty_cells();
      endfunction

      function void empty_cells();
         for (int i = 0; i < gbps_pkg::NCELLS; i++) begin
            counts[i] = '0;
            tops[i] = gbps_pkg::FLOOR_Z;
         end
      endfunction

      function void set_reg(gbps_pkg::csr_index_type idx, logic [19:0] val);
         case (idx)
            gbps_pkg::REG_WIN_MIN_X:  win_min_x = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_WIN_MAX_X:  win_max_x = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_WIN_MIN_Y:  win_min_y = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_WIN_MAX_Y:  win_max_y = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_ORIGIN_X:   org_x = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_ORIGIN_Y:   org_y = gbps_pkg::coord_type'(val);
            gbps_pkg::REG_CELL_LEN_X: len_x = val[gbps_pkg::LEN_W-1:0];
            gbps_pkg::REG_CELL_LEN_Y: len_y = val[gbps_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void absorb_request(gbps_pkg::req_type r);
         gbps_pkg::rsp_type rep;
         int dx, dy, qx, qy, c, n;
         rep = '0;
         rep.status = gbps_pkg::STAT_OK;
         rep.top_z = gbps_pkg::FLOOR_Z;
         case (r.opcode)
            gbps_pkg::OP_INSERT: begin
               if (r.point_x < win_min_x || r.point_x > win_max_x ||
                   r.point_y < win_min_y || r.point_y > win_max_y) begin
                  rep.status = gbps_pkg::STAT_OUTSIDE;
               end else if (len_x == '0 || len_y == '0) begin
                  rep.status = gbps_pkg::STAT_OFF_GRID;
               end else begin
                  dx = int'(r.point_x) - int'(org_x);
                  dy = int'(r.point_y) - int'(org_y);
                  qx = dx / int'(len_x);
                  qy = dy / int'(len_y);
                  if (qx < 0 || qx >= gbps_pkg::GRID_DIV ||
                      qy < 0 || qy >= gbps_pkg::GRID_DIV) begin
                     rep.status = gbps_pkg::STAT_OFF_GRID;
                  end else begin
                     c = qx * gbps_pkg::GRID_DIV + qy;
                     n = int'(counts[c]);
                     if (n >= gbps_pkg::CELL_CAPACITY) begin
                        rep.status = gbps_pkg::STAT_FULL;
                     end else begin
                        points[c][n].x = r.point_x;
                        points[c][n].y = r.point_y;
                        points[c][n].z = r.point_z;
                        counts[c] = 5'(n + 1);
                        if (r.point_z > tops[c]) tops[c] = r.point_z;
                     end
                     rep.cell_count = counts[c];
                     rep.top_z = tops[c];
                  end
               end
            end
            gbps_pkg::OP_READ: begin
               c = int'(r.cell_x) * gbps_pkg::GRID_DIV + int'(r.cell_y);
               n = int'(counts[c]);
               rep.cell_count = counts[c];
               rep.top_z = tops[c];
               if (int'(r.slot) >= n || int'(r.slot) >= gbps_pkg::CELL_CAPACITY) begin
                  rep.status = gbps_pkg::STAT_NO_SLOT;
               end else begin
                  rep.out_x = points[c][int'(r.slot)].x;
                  rep.out_y = points[c][int'(r.slot)].y;
                  rep.out_z = points[c][int'(r.slot)].z;
               end
            end
            gbps_pkg::OP_CLEAR: empty_cells();
            default: return;
         endcase
         cell_reports = {cell_reports, rep};
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void compare_report(gbps_pkg::rsp_type got);
         gbps_pkg::rsp_type want;
         if (cell_reports.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
            return;
         end
         want = cell_reports.pop_front();
         check_field("status", int'(want.status), int'(got.status));
         check_field("cell_count", int'(want.cell_count), int'(got.cell_count));
         check_field("top_z", int'(want.top_z), int'(got.top_z));
         check_field("out_x", int'(want.out_x), int'(got.out_x));
         check_field("out_y", int'(want.out_y), int'(got.out_y));
         check_field("out_z", int'(want.out_z), int'(got.out_z));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [19:0] csr_wdata;

   bin_store_mirror mirror;
   bit sender_gaps = 1'b0;
   bit receiver_stalls = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   grid_bin_point_store_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            mirror.absorb_request(gbps_pkg::req_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            mirror.compare_report(gbps_pkg::rsp_type'(rsp_tdata));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("grid_bin_point_store_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic gbps_pkg::req_type base_request(gbps_pkg::opcode_type op);
      gbps_pkg::req_type r;
      r.pad = '0;
      r.opcode = op;
      r.point_x = gbps_pkg::coord_type'($urandom);
      r.point_y = gbps_pkg::coord_type'($urandom);
      r.point_z = gbps_pkg::coord_type'($urandom);
      r.cell_x = 4'($urandom);
      r.cell_y = 4'($urandom);
      r.slot = 5'($urandom);
      return r;
   endfunction

   function automatic gbps_pkg::req_type insert_request(gbps_pkg::coord_type x,
                                                         gbps_pkg::coord_type y,
                                                         gbps_pkg::coord_type z);
      gbps_pkg::req_type r;
      r = base_request(gbps_pkg::OP_INSERT);
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      return r;
   endfunction

   function automatic gbps_pkg::req_type read_request(logic [3:0] cx, logic [3:0] cy,
                                                       logic [4:0] s);
      gbps_pkg::req_type r;
      r = base_request(gbps_pkg::OP_READ);
      r.cell_x = cx;
      r.cell_y = cy;
      r.slot = s;
      return r;
   endfunction

   function automatic gbps_pkg::coord_type clamp_coord(longint v);
      if (v > 524287) return COORD_MAX;
      if (v < -524288) return COORD_MIN;
      return gbps_pkg::coord_type'(v);
   endfunction

   function automatic gbps_pkg::coord_type near_grid(gbps_pkg::coord_type org,
                                                      gbps_pkg::len_type len, int q);
      longint v;
      if ($urandom_range(0, 19) == 0) return gbps_pkg::coord_type'($urandom);
      v = longint'(org) + longint'(q) * longint'(len) +
          longint'($urandom_range(0, int'(len) - 1));
      if (v > 524287 || v < -524288) return gbps_pkg::coord_type'($urandom);
      return gbps_pkg::coord_type'(v);
   endfunction

   function automatic gbps_pkg::len_type pick_len();
      case ($urandom_range(0, 4))
         0: return gbps_pkg::len_type'(1);
         1: return gbps_pkg::len_type'($urandom_range(2, 64));
         2: return gbps_pkg::len_type'($urandom_range(65, 8192));
         3: return LEN_MAX;
         default: return gbps_pkg::len_type'($urandom_range(1, 524287));
      endcase
   endfunction

   function automatic gbps_pkg::coord_type pick_origin();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return gbps_pkg::coord_type'($urandom);
      endcase
   endfunction

   task automatic send_request(gbps_pkg::req_type r);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(gbps_pkg::csr_index_type idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      mirror.set_reg(idx, val);
   endtask

   task automatic program_grid(gbps_pkg::coord_type mnx, gbps_pkg::coord_type mxx,
                               gbps_pkg::coord_type mny, gbps_pkg::coord_type mxy,
                               gbps_pkg::coord_type ox, gbps_pkg::coord_type oy,
                               gbps_pkg::len_type lx, gbps_pkg::len_type ly);
      write_reg(gbps_pkg::REG_WIN_MIN_X, mnx);
      write_reg(gbps_pkg::REG_WIN_MAX_X, mxx);
      write_reg(gbps_pkg::REG_WIN_MIN_Y, mny);
      write_reg(gbps_pkg::REG_WIN_MAX_Y, mxy);
      write_reg(gbps_pkg::REG_ORIGIN_X, ox);
      write_reg(gbps_pkg::REG_ORIGIN_Y, oy);
      write_reg(gbps_pkg::REG_CELL_LEN_X, {1'b0, lx});
      write_reg(gbps_pkg::REG_CELL_LEN_Y, {1'b0, ly});
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.cell_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(read_request(0, 0, 0));
      send_request(insert_request(5, 5, gbps_pkg::FLOOR_Z));
      send_request(insert_request(1023, 1023, COORD_MAX));
      // Small negative offsets truncate toward zero and land in the first cell.
      send_request(insert_request(-1, -1023, -5));
      send_request(insert_request(-1024, 0, 0));
      send_request(insert_request(16383, 16383, 7));
      send_request(insert_request(16384, 0, 0));
      send_request(insert_request(COORD_MIN, COORD_MAX, 0));
      send_request(insert_request(COORD_MAX, COORD_MIN, 1));
      for (int s = 0; s < 4; s++) send_request(read_request(0, 0, 5'(s)));
      send_request(read_request(15, 15, 0));
      send_request(read_request(15, 15, 31));
      send_request(base_request(gbps_pkg::OP_NONE));
      send_request(base_request(gbps_pkg::OP_CLEAR));
      send_request(read_request(0, 0, 0));
      // An inverted window rejects every point.
      settle();
      program_grid(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                   gbps_pkg::len_type'(1), LEN_MAX);
      send_request(insert_request(0, 0, 0));
      send_request(insert_request(COORD_MAX, COORD_MIN, COORD_MAX));
      settle();
      program_grid(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, '0, '0, '0,
                   gbps_pkg::len_type'(1024));
      send_request(insert_request(100, 100, 100));
      settle();
      program_grid(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                   LEN_MAX, LEN_MAX);
      send_request(insert_request(COORD_MAX, COORD_MAX, COORD_MIN));
      send_request(insert_request(COORD_MIN, COORD_MIN, 9));
      send_request(read_request(2, 2, 0));
   endtask

   task automatic random_setup();
      gbps_pkg::coord_type ox, oy, lo_x, hi_x, lo_y, hi_y;
      gbps_pkg::len_type   lx, ly;
      ox = pick_origin();
      oy = pick_origin();
      lx = pick_len();
      ly = pick_len();
      case ($urandom_range(0, 5))
         0, 1: begin
            lo_x = COORD_MIN;
            hi_x = COORD_MAX;
            lo_y = COORD_MIN;
            hi_y = COORD_MAX;
         end
         2, 3, 4: begin
            lo_x = clamp_coord(longint'(ox) - longint'($urandom_range(0, 2)) * longint'(lx));
            hi_x = clamp_coord(longint'(ox) + longint'($urandom_range(12, 17)) * longint'(lx));
            lo_y = clamp_coord(longint'(oy) - longint'($urandom_range(0, 2)) * longint'(ly));
            hi_y = clamp_coord(longint'(oy) + longint'($urandom_range(12, 17)) * longint'(ly));
         end
         default: begin
            lo_x = gbps_pkg::coord_type'($urandom);
            hi_x = gbps_pkg::coord_type'($urandom);
            lo_y = gbps_pkg::coord_type'($urandom);
            hi_y = gbps_pkg::coord_type'($urandom);
         end
      endcase
      program_grid(lo_x, hi_x, lo_y, hi_y, ox, oy, lx, ly);
   endtask

   task automatic run_random(int target);
      int                  sent, hot_count, hot_pct, h, qx, qy, roll;
      int                  hot_col [4];
      int                  hot_row [4];
      gbps_pkg::req_type   r;
      gbps_pkg::coord_type z;
      sent = 0;
      hot_count = $urandom_range(1, 4);
      hot_pct = $urandom_range(30, 90);
      for (int i = 0; i < 4; i++) begin
         hot_col[i] = $urandom_range(0, 15);
         hot_row[i] = $urandom_range(0, 15);
      end
      while (sent < target) begin
         h = $urandom_range(0, hot_count - 1);
         if ($urandom_range(1, 100) <= hot_pct) begin
            qx = hot_col[h];
            qy = hot_row[h];
         end else begin
            qx = int'($urandom_range(0, 17)) - 1;
            qy = int'($urandom_range(0, 17)) - 1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            z = ($urandom_range(0, 9) == 0) ? COORD_MAX : gbps_pkg::coord_type'($urandom);
            r = insert_request(near_grid(mirror.org_x, mirror.len_x, qx),
                               near_grid(mirror.org_y, mirror.len_y, qy), z);
         end else if (roll < 95) begin
            r = read_request(4'(qx), 4'(qy), ($urandom_range(0, 3) == 0) ?
                             5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16)));
         end else if (roll < 97) begin
            r = base_request(gbps_pkg::OP_CLEAR);
         end else begin
            r = base_request(gbps_pkg::OP_NONE);
         end
         send_request(r);
         if (r.opcode != gbps_pkg::OP_NONE) sent++;
      end
   endtask

   initial begin
      mirror = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         settle();
         random_setup();
         sender_gaps = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
         run_random(PHASE_ITEMS);
      end
      settle();
      if (mirror.errors == 0) begin
         $display("grid_bin_point_store_top verification clean");
      end else begin
         $display("grid_bin_point_store_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/gbps_pkg.sv
src/gbps_div.sv
src/gbps_point_ram.sv
src/grid_bin_point_store_top.sv
sim/tb_grid_bin_point_store_top.sv
